// ===== sv/xzis_pkg.sv =====
// ----------------------------------------------------------------------------
// xzis_pkg
// Shared types and constants for the xz index size summer: transaction
// structs, status codes, footer magic bytes and varint limits.
// ----------------------------------------------------------------------------
package xzis_pkg;

    // Default byte store depth
    localparam int BUF_DEPTH_DEF = 4096;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOMAGIC   = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    // Footer magic bytes
    localparam logic [7:0] CHAR_Y = 8'h59;
    localparam logic [7:0] CHAR_Z = 8'h5A;

    // Varint limits: 7 payload bits per byte, at most 9 bytes
    localparam int         DIGIT_BITS     = 7;
    localparam logic [3:0] VARINT_MAX_LEN = 4'd9;

    // Which index field the varint unit is decoding
    localparam logic [1:0] FLD_COUNT  = 2'd0;
    localparam logic [1:0] FLD_UNPAD  = 2'd1;
    localparam logic [1:0] FLD_UNCOMP = 2'd2;

    // Width of the signed backward jump arithmetic (34-bit index size + offset + sign)
    localparam int JUMP_W = 36;

    // Distance from the last backward-size byte to the index record count, minus 4*bw
    localparam int JUMP_OFS = 10;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [63:0] total_size;
        logic [1:0]  status;
    } t_out_item;

endpackage

// ===== sv/xzis_byte_ram.sv =====
// ----------------------------------------------------------------------------
// xzis_byte_ram
// Single-port-write, single-port-read byte memory with registered read data.
// ----------------------------------------------------------------------------
module xzis_byte_ram #(
    parameter int DEPTH = xzis_pkg::BUF_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]               i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [7:0]               o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/xz_index_size_summer.sv =====
// ----------------------------------------------------------------------------
// xz_index_size_summer
// Loads one xz stream byte by byte and, after the byte marked last, walks the
// stream index and reports the total uncompressed size with a status code.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the block is loading. The transaction
// carrying the last byte starts a scan that reads the byte store once per
// cycle through its single registered read port: it skips trailing zero
// padding, checks the footer magic, collects the backward size, jumps back
// over the index and decodes each index byte (record count, then unpadded
// and uncompressed size of every record). The handover to the output
// register waits while that register still holds an earlier result that is
// stalled. Input is stalled for the whole scan; the result then waits
// in an output register, and loading of the next stream resumes once the
// result has been handed over to that register. Status is 0 ok, 1 footer
// magic missing, 2 malformed (byte store overflow, bad varint or out-of-range
// offset); on a nonzero status total_size is zero.
module xz_index_size_summer #(
    parameter int BUF_DEPTH = xzis_pkg::BUF_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  xzis_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output xzis_pkg::t_out_item  o_out_data
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam int PW = CW + 1;
    localparam int JW = xzis_pkg::JUMP_W;

    // Sequencer states
    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_BACK   = 4'd2;
    localparam logic [3:0] S_Y      = 4'd3;
    localparam logic [3:0] S_BW     = 4'd4;
    localparam logic [3:0] S_JUMP   = 4'd5;
    localparam logic [3:0] S_VFIRST = 4'd6;
    localparam logic [3:0] S_VNEXT  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]          r_state, n_state;
    logic [CW-1:0]       r_fill, n_fill;
    logic                r_ovf, n_ovf;
    logic [PW-1:0]       r_ptr, n_ptr;
    logic [1:0]          r_cnt, n_cnt;
    logic [31:0]         r_bw, n_bw;
    logic [1:0]          r_field, n_field;
    logic [3:0]          r_vlen, n_vlen;
    logic [63:0]         r_val, n_val;
    logic [63:0]         r_count, n_count;
    logic [63:0]         r_idx, n_idx;
    logic [63:0]         r_sum, n_sum;
    logic [1:0]          r_status, n_status;
    logic                r_out_valid, n_out_valid;
    xzis_pkg::t_out_item r_out, n_out;

    logic                in_acc;
    logic                out_acc;
    logic                wr_en;
    logic [7:0]          rd_data;
    logic                v_done;
    logic                ptr_past_fill;
    logic [PW-1:0]       ptr_y;
    logic [JW-1:0]       jump_ptr;
    logic [6:0]          dig_shift;
    logic [63:0]         digit;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_out_valid && !i_out_stall;
    assign wr_en   = in_acc && (r_fill != CW'(BUF_DEPTH));

    xzis_byte_ram #(
        .DEPTH (BUF_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (i_in_data.data_byte),
        .i_rd_addr (n_ptr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Shared datapath pieces
    assign ptr_past_fill = (r_ptr >= {1'b0, r_fill});
    assign ptr_y         = r_ptr - PW'(6);
    assign jump_ptr      = JW'(signed'({{(JW-PW){r_ptr[PW-1]}}, r_ptr}))
                         - JW'(xzis_pkg::JUMP_OFS)
                         - {{(JW-34){1'b0}}, r_bw, 2'b00};
    assign dig_shift     = 7'(r_vlen) * 7'(xzis_pkg::DIGIT_BITS);
    assign digit         = {57'd0, rd_data[6:0]} << dig_shift;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_ovf       = r_ovf;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_bw        = r_bw;
        n_field     = r_field;
        n_vlen      = r_vlen;
        n_val       = r_val;
        n_count     = r_count;
        n_idx       = r_idx;
        n_sum       = r_sum;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        v_done      = 1'b0;

        if (out_acc) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (wr_en) begin
                        n_fill = r_fill + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.last_byte) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_ptr = {1'b0, r_fill} - PW'(1);
                if (r_ovf) begin
                    n_status = xzis_pkg::ST_MALFORMED;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_BACK;
                end
            end
            // Skip trailing zero padding, then expect 'Z'
            S_BACK: begin
                if (rd_data == 8'd0) begin
                    if (r_ptr == '0) begin
                        n_status = xzis_pkg::ST_MALFORMED;
                        n_state  = S_DONE;
                    end else begin
                        n_ptr = r_ptr - PW'(1);
                    end
                end else if (rd_data != xzis_pkg::CHAR_Z) begin
                    n_status = xzis_pkg::ST_NOMAGIC;
                    n_state  = S_DONE;
                end else if (r_ptr == '0) begin
                    n_status = xzis_pkg::ST_MALFORMED;
                    n_state  = S_DONE;
                end else begin
                    n_ptr   = r_ptr - PW'(1);
                    n_state = S_Y;
                end
            end
            // Expect 'Y', then step back to the backward size field
            S_Y: begin
                if (rd_data != xzis_pkg::CHAR_Y) begin
                    n_status = xzis_pkg::ST_NOMAGIC;
                    n_state  = S_DONE;
                end else if (ptr_y[PW-1]) begin
                    n_status = xzis_pkg::ST_MALFORMED;
                    n_state  = S_DONE;
                end else begin
                    n_ptr   = ptr_y;
                    n_cnt   = 2'd0;
                    n_state = S_BW;
                end
            end
            // Collect the 32-bit little-endian backward size
            S_BW: begin
                n_bw  = {rd_data, r_bw[31:8]};
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = S_JUMP;
                end else begin
                    n_ptr = r_ptr + PW'(1);
                end
            end
            // Jump back over the index
            S_JUMP: begin
                if (jump_ptr[JW-1]) begin
                    n_status = xzis_pkg::ST_MALFORMED;
                    n_state  = S_DONE;
                end else begin
                    n_ptr   = jump_ptr[PW-1:0];
                    n_field = xzis_pkg::FLD_COUNT;
                    n_state = S_VFIRST;
                end
            end
            // Varint unit: first byte
            S_VFIRST: begin
                if (ptr_past_fill) begin
                    n_status = xzis_pkg::ST_MALFORMED;
                    n_state  = S_DONE;
                end else begin
                    n_val  = {57'd0, rd_data[6:0]};
                    n_vlen = 4'd1;
                    if (rd_data[7]) begin
                        n_ptr   = r_ptr + PW'(1);
                        n_state = S_VNEXT;
                    end else begin
                        v_done = 1'b1;
                    end
                end
            end
            // Varint unit: continuation bytes, one digit per cycle
            S_VNEXT: begin
                if (ptr_past_fill || (r_vlen >= xzis_pkg::VARINT_MAX_LEN)
                        || (rd_data == 8'd0)) begin
                    n_status = xzis_pkg::ST_MALFORMED;
                    n_state  = S_DONE;
                end else begin
                    n_val  = r_val | digit;
                    n_vlen = r_vlen + 4'd1;
                    if (rd_data[7]) begin
                        n_ptr = r_ptr + PW'(1);
                    end else begin
                        v_done = 1'b1;
                    end
                end
            end
            // Hand the result to the output register when it is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid      = 1'b1;
                    n_out.status     = r_status;
                    n_out.total_size = (r_status == xzis_pkg::ST_OK) ? r_sum : 64'd0;
                    n_fill           = '0;
                    n_ovf            = 1'b0;
                    n_state          = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // Dispatch a decoded varint to its index field
        if (v_done) begin
            n_ptr   = r_ptr + PW'(1);
            n_state = S_VFIRST;
            case (r_field)
                xzis_pkg::FLD_COUNT: begin
                    n_count = n_val;
                    n_idx   = 64'd0;
                    n_sum   = 64'd0;
                    n_field = xzis_pkg::FLD_UNPAD;
                    if (n_val == 64'd0) begin
                        n_status = xzis_pkg::ST_OK;
                        n_state  = S_DONE;
                    end
                end
                xzis_pkg::FLD_UNPAD: begin
                    n_field = xzis_pkg::FLD_UNCOMP;
                end
                xzis_pkg::FLD_UNCOMP: begin
                    n_sum   = r_sum + n_val;
                    n_idx   = r_idx + 64'd1;
                    n_field = xzis_pkg::FLD_UNPAD;
                    if (r_idx + 64'd1 == r_count) begin
                        n_status = xzis_pkg::ST_OK;
                        n_state  = S_DONE;
                    end
                end
                default: begin
                    n_status = xzis_pkg::ST_MALFORMED;
                    n_state  = S_DONE;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_cnt    <= n_cnt;
        r_bw     <= n_bw;
        r_field  <= n_field;
        r_vlen   <= n_vlen;
        r_val    <= n_val;
        r_count  <= n_count;
        r_idx    <= n_idx;
        r_sum    <= n_sum;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(BUF_DEPTH))
        else $error("fill count beyond store depth");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside the done state");

    a_varint_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VNEXT) |-> (r_vlen >= 4'd1 && r_vlen <= xzis_pkg::VARINT_MAX_LEN))
        else $error("varint length out of range");

    a_ptr_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VFIRST || r_state == S_VNEXT) |-> !r_ptr[PW-1])
        else $error("scan pointer negative during index walk");

endmodule
